// ===== rtl/fpia_pkg.sv =====
// ----------------------------------------------------------------------------
// Fixed-position interval allocator: shared definitions
// Field widths, default sizes and the beat and table entry types used by the
// channel interfaces, the allocation engine and the top level.
// ----------------------------------------------------------------------------
package fpia_pkg;

  // Field widths of the channels.
  localparam int StartW    = 10;
  localparam int LenW      = 11;
  localparam int SizeW     = 11;
  localparam int CountOutW = 7;

  // Start plus length, wide enough for any pair of fields.
  localparam int SumW = 12;

  // Default table depth and managed memory size.
  localparam int DefMaxRegions = 64;
  localparam int DefMemCells   = 1024;

  // One request beat.
  typedef struct packed {
    logic [StartW-1:0] start_cell;
    logic [LenW-1:0]   length_cells;
    logic              allow_shift;
  } req_t;

  // One response beat.
  typedef struct packed {
    logic                 granted;
    logic                 moved;
    logic [StartW-1:0]    moved_to;
    logic [CountOutW-1:0] region_count;
  } res_t;

  // One entry of the region table.
  typedef struct packed {
    logic [StartW-1:0] start;
    logic [LenW-1:0]   len;
  } entry_t;

endpackage

// ===== rtl/fpia_if.sv =====
// ----------------------------------------------------------------------------
// Fixed-position interval allocator: channel interfaces
// Valid/ready channels for configuration writes, requests and responses.
// ----------------------------------------------------------------------------

// Configuration write channel carrying the memory size.
interface fpia_cfg_if import fpia_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SizeW-1:0] memory_size;

  modport source (output valid, output memory_size, input ready);
  modport sink   (input valid, input memory_size, output ready);
endinterface

// Request channel.
interface fpia_req_if import fpia_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [StartW-1:0] start_cell;
  logic [LenW-1:0]   length_cells;
  logic              allow_shift;

  modport source (output valid, output start_cell, output length_cells,
                  output allow_shift, input ready);
  modport sink   (input valid, input start_cell, input length_cells,
                  input allow_shift, output ready);
endinterface

// Response channel.
interface fpia_rsp_if import fpia_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 granted;
  logic                 moved;
  logic [StartW-1:0]    moved_to;
  logic [CountOutW-1:0] region_count;

  modport source (output valid, output granted, output moved, output moved_to,
                  output region_count, input ready);
  modport sink   (input valid, input granted, input moved, input moved_to,
                  input region_count, output ready);
endinterface

// ===== rtl/fpia_engine.sv =====
// ----------------------------------------------------------------------------
// Fixed-position interval allocator: allocation engine
// Holds the sorted region table in a synchronous memory and runs one request
// at a time: scan, decide, shift the tail up by one entry, insert.
// ----------------------------------------------------------------------------
module fpia_engine import fpia_pkg::*; #(
  parameter int MAX_REGIONS = DefMaxRegions
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  logic [SizeW-1:0] size_i,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  req_t             req_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output res_t             res_o
);

  localparam int AW = $clog2(MAX_REGIONS);
  localparam int CW = $clog2(MAX_REGIONS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_NEXT = 3'd2;
  localparam logic [2:0] S_MOVE = 3'd3;
  localparam logic [2:0] S_INS  = 3'd4;
  localparam logic [2:0] S_MVW  = 3'd5;
  localparam logic [2:0] S_RESP = 3'd6;

  // Control state.
  logic [2:0]      state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   ridx_q, ridx_d;
  logic            pend_q, pend_d;
  logic [CW-1:0]   rdst_q, rdst_d;
  logic            wpend_q, wpend_d;

  // Per-request payload.
  req_t              req_q, req_d;
  logic [SumW-1:0]   sum_q, sum_d;
  logic [CW-1:0]     succ_q, succ_d;
  logic              found_q, found_d;
  logic              has_next_q, has_next_d;
  entry_t            ent_q, ent_d;
  logic              granted_q, granted_d;
  logic              moved_q, moved_d;
  logic [StartW-1:0] moved_to_q, moved_to_d;
  logic [CW-1:0]     wdst_q, wdst_d;

  // Memory ports.
  entry_t          mem_q [MAX_REGIONS];
  entry_t          rd_q;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  entry_t          wr_data;

  // Decision terms.
  logic            refuse_now;
  logic            issue;
  logic            hit;
  logic [SumW-1:0] limit;
  logic [SumW-1:0] limit2;
  logic [SumW:0]   moved_end;
  logic            collide;
  logic            fits_move;

  // A request is refused up front for zero length, a start outside memory or a
  // full table.
  assign refuse_now = (req_i.length_cells == '0) ||
                      (SizeW'(req_i.start_cell) >= size_i) ||
                      (count_q >= CW'(MAX_REGIONS));

  // Scan terms: the data in rd_q belongs to entry ridx_q - 1 when pend_q is set.
  assign issue = (ridx_q < count_q);
  assign hit   = pend_q &&
                 (SumW'(req_q.start_cell) < (SumW'(rd_q.start) + SumW'(rd_q.len)));

  // Collision and shift-fit terms, evaluated in the decide cycle.
  assign limit     = found_q ? SumW'(ent_q.start) : SumW'(size_i);
  assign limit2    = has_next_q ? SumW'(rd_q.start) : SumW'(size_i);
  assign moved_end = (SumW + 1)'(sum_q) + (SumW + 1)'(ent_q.len);
  assign collide   = (sum_q > limit);
  assign fits_move = (moved_end <= (SumW + 1)'(limit2));

  // Sequencer and memory port control.
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    ridx_d     = ridx_q;
    pend_d     = pend_q;
    rdst_d     = rdst_q;
    wpend_d    = wpend_q;
    req_d      = req_q;
    sum_d      = sum_q;
    succ_d     = succ_q;
    found_d    = found_q;
    has_next_d = has_next_q;
    ent_d      = ent_q;
    granted_d  = granted_q;
    moved_d    = moved_q;
    moved_to_d = moved_to_q;
    wdst_d     = wdst_q;
    rd_en      = 1'b0;
    rd_addr    = ridx_q[AW-1:0];
    wr_en      = 1'b0;
    wr_addr    = wdst_q[AW-1:0];
    wr_data    = rd_q;

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          req_d      = req_i;
          sum_d      = SumW'(req_i.start_cell) + SumW'(req_i.length_cells);
          granted_d  = 1'b0;
          moved_d    = 1'b0;
          moved_to_d = '0;
          ridx_d     = '0;
          pend_d     = 1'b0;
          state_d    = refuse_now ? S_RESP : S_SCAN;
        end
      end

      // Stream the table out one entry a cycle and stop at the first region
      // that ends past the requested start.
      S_SCAN: begin
        rd_en   = issue;
        rd_addr = ridx_q[AW-1:0];
        if (issue) begin
          ridx_d = ridx_q + 1'b1;
        end
        pend_d = issue;
        if (hit) begin
          succ_d     = ridx_q - 1'b1;
          ent_d      = rd_q;
          found_d    = 1'b1;
          has_next_d = issue;
          state_d    = S_NEXT;
        end else if (!issue) begin
          succ_d     = count_q;
          found_d    = 1'b0;
          has_next_d = 1'b0;
          state_d    = S_NEXT;
        end
      end

      // rd_q now holds the entry after the successor, if there is one.
      S_NEXT: begin
        rdst_d  = count_q;
        wpend_d = 1'b0;
        if (!collide) begin
          granted_d = 1'b1;
          state_d   = S_MOVE;
        end else if (req_q.allow_shift && found_q && fits_move) begin
          granted_d  = 1'b1;
          moved_d    = 1'b1;
          moved_to_d = sum_q[StartW-1:0];
          state_d    = S_MOVE;
        end else begin
          state_d = S_RESP;
        end
      end

      // Copy entries one place up, from the top down to the successor. A read
      // of entry d - 1 is written to entry d in the next cycle, so no read ever
      // hits an entry that was just written.
      S_MOVE: begin
        wr_en   = wpend_q;
        wr_addr = wdst_q[AW-1:0];
        wr_data = rd_q;
        if (rdst_q > succ_q) begin
          rd_en   = 1'b1;
          rd_addr = AW'(rdst_q - 1'b1);
          wdst_d  = rdst_q;
          rdst_d  = rdst_q - 1'b1;
          wpend_d = 1'b1;
        end else begin
          wpend_d = 1'b0;
          state_d = S_INS;
        end
      end

      // Place the new region at the successor's slot.
      S_INS: begin
        wr_en   = 1'b1;
        wr_addr = succ_q[AW-1:0];
        wr_data = '{start: req_q.start_cell, len: req_q.length_cells};
        count_d = count_q + 1'b1;
        state_d = moved_q ? S_MVW : S_RESP;
      end

      // The shifted region lands one slot up with its new start.
      S_MVW: begin
        wr_en   = 1'b1;
        wr_addr = AW'(succ_q + 1'b1);
        wr_data = '{start: moved_to_q, len: ent_q.len};
        state_d = S_RESP;
      end

      S_RESP: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A write of the memory size empties the table.
    if (clear_i) begin
      count_d = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      ridx_q  <= '0;
      pend_q  <= 1'b0;
      rdst_q  <= '0;
      wpend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ridx_q  <= ridx_d;
      pend_q  <= pend_d;
      rdst_q  <= rdst_d;
      wpend_q <= wpend_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    sum_q      <= sum_d;
    succ_q     <= succ_d;
    found_q    <= found_d;
    has_next_q <= has_next_d;
    ent_q      <= ent_d;
    granted_q  <= granted_d;
    moved_q    <= moved_d;
    moved_to_q <= moved_to_d;
    wdst_q     <= wdst_d;
  end

  // Region table: one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_RESP);
  assign res_o       = '{granted:      granted_q,
                         moved:        moved_q,
                         moved_to:     moved_to_q,
                         region_count: CountOutW'(count_q)};

endmodule

// ===== rtl/fixed_position_interval_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// Fixed-position interval allocator
// Grants regions at a requested start over a managed memory, moving the next
// region up when allowed, and keeps a sorted table of regions.
// ----------------------------------------------------------------------------
// Usage:
//   cfg carries the memory size; a beat sets it (saturated at MEM_CELLS) and
//   empties the table. Write it only while no request is in flight.
//   req carries one request beat (start, length, shift permission); rsp
//   returns exactly one beat per request: granted, moved, the moved region's
//   new start and the region count after the request.
//   Requests are handled one at a time. A request with a valid length, start
//   and table room scans the table linearly; a granted one then copies the
//   tail up one entry per cycle through the single memory port, inserts and,
//   when a region moves, rewrites it. A refusal for length, start or full
//   table skips the scan and goes straight to the response.
//   The response sits in an output register, so a new request is taken
//   while an earlier response waits. When the receiver stalls, the engine
//   holds its finished result until the register frees.
//   Reset empties the table and sets the memory size to zero, so every
//   request is refused until a size is written. No clearing pass is needed.
// ----------------------------------------------------------------------------
module fixed_position_interval_allocator_unit import fpia_pkg::*; #(
  parameter int MAX_REGIONS = DefMaxRegions,
  parameter int MEM_CELLS   = DefMemCells
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fpia_cfg_if.sink   cfg,
  fpia_req_if.sink   req,
  fpia_rsp_if.source rsp
);

  logic [SizeW-1:0] memory_size_q, memory_size_d;
  logic [SizeW-1:0] size;
  logic             clear;
  logic             eng_res_valid;
  logic             eng_res_ready;
  res_t             eng_res;
  req_t             req_beat;
  logic             out_valid_q, out_valid_d;
  res_t             out_q;

  // Configuration writes are always taken.
  assign cfg.ready = 1'b1;
  assign clear     = cfg.valid & cfg.ready;

  always_comb begin
    memory_size_d = clear ? cfg.memory_size : memory_size_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      memory_size_q <= '0;
    end else begin
      memory_size_q <= memory_size_d;
    end
  end

  // Effective size, saturated at the managed memory size.
  always_comb begin
    if (int'(memory_size_q) > MEM_CELLS) begin
      size = SizeW'(MEM_CELLS);
    end else begin
      size = memory_size_q;
    end
  end

  assign req_beat = '{start_cell:   req.start_cell,
                      length_cells: req.length_cells,
                      allow_shift:  req.allow_shift};

  fpia_engine #(
    .MAX_REGIONS(MAX_REGIONS)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (clear),
    .size_i     (size),
    .req_valid_i(req.valid),
    .req_ready_o(req.ready),
    .req_i      (req_beat),
    .res_valid_o(eng_res_valid),
    .res_ready_i(eng_res_ready),
    .res_o      (eng_res)
  );

  // Output register: loads when empty or when its beat leaves this cycle.
  assign eng_res_ready = !out_valid_q || rsp.ready;

  always_comb begin
    if (eng_res_valid && eng_res_ready) begin
      out_valid_d = 1'b1;
    end else if (rsp.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eng_res_valid && eng_res_ready) begin
      out_q <= eng_res;
    end
  end

  assign rsp.valid        = out_valid_q;
  assign rsp.granted      = out_q.granted;
  assign rsp.moved        = out_q.moved;
  assign rsp.moved_to     = out_q.moved_to;
  assign rsp.region_count = out_q.region_count;

  // A refused request never reports a moved region.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && !rsp.granted |-> !rsp.moved && (rsp.moved_to == '0))
    else $error("refused response reports a moved region");

  // A moved region always comes with a grant.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp.moved |-> rsp.granted)
    else $error("moved region without a grant");

  // The engine works on one request at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while the engine is busy");

  // A stalled response beat is never overwritten by the engine.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !rsp.ready |-> !(eng_res_valid && eng_res_ready))
    else $error("output register overwritten while stalled");

endmodule

// ===== dv/fixed_position_interval_allocator_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Fixed-position interval allocator: unit testbench
// Drives allocation requests through the request channel and checks every
// response beat against a region table kept alongside the block. A directed
// opening covers refusals, collisions, moves that fit and moves that do not;
// random phases over several memory sizes follow, with idling on both sides
// and one long response hold-off that backs the block up.
// ----------------------------------------------------------------------------
module fixed_position_interval_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fpia_pkg::*;

  localparam int TableDepth  = DefMaxRegions;
  localparam int MemCap      = DefMemCells;
  localparam int PhaseItems  = 216;
  localparam int HoldCycles  = 400;
  localparam int StallLimit  = 3000;
  localparam int DrainCycles = 2 * DefMaxRegions + 16;

  logic clk_i = 1'b0;
  logic rst_ni;

  fpia_cfg_if cfg_bus ();
  fpia_req_if req_bus ();
  fpia_rsp_if rsp_bus ();

  fixed_position_interval_allocator_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg    (cfg_bus),
    .req    (req_bus),
    .rsp    (rsp_bus)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Region table as the block should hold it.
  logic [StartW-1:0]    tbl_start [TableDepth];
  logic [LenW-1:0]      tbl_len   [TableDepth];
  logic [CountOutW-1:0] tbl_count;
  logic [SizeW-1:0]     mem_size;

  req_t pending_req [$];
  res_t grant_q     [$];

  int   errors = 0;
  int   src_idle_pct = 0;
  int   sink_stall_pct = 0;
  logic hold_req = 1'b0;
  logic hold_rsp = 1'b0;
  int   quiet_cycles = 0;

  // Works out the response to one request and updates the table.
  function automatic res_t predict_alloc(req_t r);
    res_t o;
    int   sz, cnt, succ, lim, lim2, npos, st, ln;
    o    = '0;
    sz   = (int'(mem_size) > MemCap) ? MemCap : int'(mem_size);
    cnt  = int'(tbl_count);
    st   = int'(r.start_cell);
    ln   = int'(r.length_cells);
    o.region_count = tbl_count;
    if (ln == 0 || st >= sz || cnt >= TableDepth) return o;
    // First region whose last cell is at or after the requested start.
    succ = 0;
    while (succ < cnt && st >= int'(tbl_start[succ]) + int'(tbl_len[succ])) succ++;
    lim = (succ < cnt) ? int'(tbl_start[succ]) : sz;
    // A collision needs permission and room to push that region up.
    if (st + ln > lim) begin
      if (!r.allow_shift || succ >= cnt) return o;
      npos = st + ln;
      lim2 = (succ + 1 < cnt) ? int'(tbl_start[succ + 1]) : sz;
      if (npos + int'(tbl_len[succ]) > lim2) return o;
      tbl_start[succ] = npos[StartW-1:0];
      o.moved    = 1'b1;
      o.moved_to = npos[StartW-1:0];
    end
    // Sorted insertion.
    for (int i = cnt; i > succ; i--) begin
      tbl_start[i] = tbl_start[i - 1];
      tbl_len[i]   = tbl_len[i - 1];
    end
    tbl_start[succ] = r.start_cell;
    tbl_len[succ]   = r.length_cells;
    tbl_count       = CountOutW'(cnt + 1);
    o.granted       = 1'b1;
    o.region_count  = tbl_count;
    return o;
  endfunction

  function automatic req_t make_req(int st, int ln, bit sh);
    req_t r;
    r.start_cell   = st[StartW-1:0];
    r.length_cells = ln[LenW-1:0];
    r.allow_shift  = sh;
    return r;
  endfunction

  // Random request, mostly well formed for the given memory size.
  function automatic req_t rand_request(int size);
    int span, pick, st, ln, small_max;
    span      = (size > MemCap) ? MemCap : size;
    small_max = span / 64 + 1;
    pick      = $urandom_range(99);
    if (span == 0 || pick < 8) st = $urandom_range(MemCap - 1);
    else st = $urandom_range(span - 1);
    pick = $urandom_range(99);
    if (pick < 4) ln = 0;
    else if (pick < 7) ln = MemCap;
    else if (pick < 14) ln = $urandom_range(MemCap, 1);
    else if (pick < 60) ln = 1;
    else ln = $urandom_range(small_max + 2, 1);
    return make_req(st, ln, 1'($urandom_range(1)));
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Writes the memory size and empties the table.
  task automatic write_mem_size(input int value);
    @(posedge clk_i);
    cfg_bus.valid       <= 1'b1;
    cfg_bus.memory_size <= value[SizeW-1:0];
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    mem_size  = value[SizeW-1:0];
    tbl_count = '0;
  endtask

  // Waits until every queued request has been answered.
  task automatic wait_drained();
    do @(negedge clk_i); while (pending_req.size() != 0 || req_bus.valid ||
                                grant_q.size() != 0);
  endtask

  // Request driver: offers the next pending request, holding it until taken.
  always @(posedge clk_i) begin : req_driver
    req_t acc, nxt;
    if (rst_ni) begin
      if (req_bus.valid && req_bus.ready) begin
        acc = make_req(int'(req_bus.start_cell), int'(req_bus.length_cells),
                       req_bus.allow_shift);
        grant_q.push_back(predict_alloc(acc));
      end
      if (!req_bus.valid || req_bus.ready) begin
        if (pending_req.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          nxt = pending_req.pop_front();
          req_bus.valid        <= 1'b1;
          req_bus.start_cell   <= nxt.start_cell;
          req_bus.length_cells <= nxt.length_cells;
          req_bus.allow_shift  <= nxt.allow_shift;
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end else begin
      req_bus.valid        <= 1'b0;
      req_bus.start_cell   <= '0;
      req_bus.length_cells <= '0;
      req_bus.allow_shift  <= 1'b0;
    end
  end

  // Response monitor: checks each beat and stalls at random.
  always @(posedge clk_i) begin : rsp_monitor
    res_t want;
    if (rst_ni) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (grant_q.size() == 0) begin
          $display("%0t: response beat with nothing expected, expected none, got granted=%0d",
                   $time, rsp_bus.granted);
          errors++;
        end else begin
          want = grant_q.pop_front();
          check_field("granted", int'(want.granted), int'(rsp_bus.granted));
          check_field("moved", int'(want.moved), int'(rsp_bus.moved));
          check_field("moved_to", int'(want.moved_to), int'(rsp_bus.moved_to));
          check_field("region_count", int'(want.region_count),
                      int'(rsp_bus.region_count));
        end
      end
      rsp_bus.ready <= !hold_rsp && ($urandom_range(99) >= sink_stall_pct);
    end else begin
      rsp_bus.ready <= 1'b0;
    end
  end

  // Long response hold-off while requests keep coming.
  initial begin
    wait (hold_req);
    @(posedge clk_i);
    hold_rsp <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_rsp <= 1'b0;
  end

  // Watchdog on cycles without any beat.
  always @(posedge clk_i) begin
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus sequence.
  initial begin : stimulus
    int phase_size [8];
    int sz;
    phase_size = '{128, 1024, 96, 2047, 200, 1, 64, 0};
    rst_ni               = 1'b0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.memory_size  = '0;
    mem_size             = '0;
    tbl_count            = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Out of reset the memory size is zero, so everything is refused.
    pending_req.push_back(make_req(0, 1, 1'b0));
    pending_req.push_back(make_req(5, MemCap, 1'b1));
    wait_drained();

    // Small memory: refusals, a collision with and without a move, a move
    // that does not fit and a request running past the memory end.
    write_mem_size(16);
    pending_req.push_back(make_req(0, 0, 1'b0));
    pending_req.push_back(make_req(16, 1, 1'b0));
    pending_req.push_back(make_req(MemCap - 1, 1, 1'b1));
    pending_req.push_back(make_req(8, 9, 1'b1));
    pending_req.push_back(make_req(4, 4, 1'b0));
    pending_req.push_back(make_req(2, 4, 1'b0));
    pending_req.push_back(make_req(2, 4, 1'b1));
    pending_req.push_back(make_req(12, 4, 1'b0));
    pending_req.push_back(make_req(10, 4, 1'b1));
    pending_req.push_back(make_req(15, 2, 1'b1));
    pending_req.push_back(make_req(0, 2, 1'b0));
    pending_req.push_back(make_req(10, 2, 1'b0));
    pending_req.push_back(make_req(0, MemCap, 1'b1));
    wait_drained();

    // Oversized memory: saturates, extremes of start and length.
    write_mem_size(2047);
    pending_req.push_back(make_req(MemCap - 1, 1, 1'b0));
    pending_req.push_back(make_req(0, MemCap, 1'b1));
    pending_req.push_back(make_req(0, MemCap - 1, 1'b1));
    pending_req.push_back(make_req(512, 1, 1'b1));
    pending_req.push_back(make_req(MemCap - 1, 1, 1'b0));
    wait_drained();

    // Random phases, cycling through the idling patterns.
    for (int ph = 0; ph < 8; ph++) begin
      sz = (phase_size[ph] == 0) ? $urandom_range(MemCap, 2) : phase_size[ph];
      case (ph % 4)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct   = 71;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct = 71;
        end
        default: begin
          src_idle_pct   = 21;
          sink_stall_pct = 21;
        end
      endcase
      write_mem_size(sz);
      for (int k = 0; k < PhaseItems; k++) pending_req.push_back(rand_request(sz));
      if (ph == 0) hold_req = 1'b1;
      wait_drained();
    end

    src_idle_pct   = 0;
    sink_stall_pct = 0;
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
